// ----- design/qte_pkg.sv -----
// shared types, widths and constants for the quaternion to euler angle converter
package qte_pkg;

   // front-end operand width: sums of two products times two
   localparam int OW = 34;
   // cordic datapath width and angle width (30 fraction bits)
   localparam int CW = 45;
   localparam int ZW = 34;
   // square root: radicand, root and trial widths
   localparam int RW = 57;
   localparam int QW = 29;
   localparam int TW = 60;
   localparam int SQRT_BITS = 29;
   // normalisation: operands brought up until the magnitude reaches bit NORM_TOP
   localparam int NORM_TOP = 40;
   localparam int NORM_CELLS = 6;
   localparam int NORM_FIRST = 32;
   localparam int TABLE_LEN = 24;

   localparam logic signed [OW-1:0] ONE_Q28 = 34'sd268435456;
   localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [22:0] DEG_PER_RAD_Q16 = 23'sd3754936;

   // atan(2^-i) with 30 fraction bits
   localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
      32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
      32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128
   };

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] angle_about_x;
      logic signed [15:0] angle_about_y;
      logic signed [15:0] angle_about_z;
      logic               y_saturated;
   } rsp_payload_type;

   // vector handed from cell to cell in a cordic lane
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 hold;
   } cordic_vec_type;

endpackage

// ----- design/qte_stream_if.sv -----
// valid/ready stream interface with a typed payload
interface qte_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/qte_sqrt_cell.sv -----
// one result bit of the integer square root chain
module qte_sqrt_cell #(
   parameter int BIT = 0
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [qte_pkg::RW-1:0]  src_rem,
   input  logic [qte_pkg::QW-1:0]  src_root,
   output logic [qte_pkg::RW-1:0]  dst_rem,
   output logic [qte_pkg::QW-1:0]  dst_root
);
   import qte_pkg::*;

   logic [TW-1:0] trial;
   logic          fits;
   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] root_ff, root_in;

   // (root + 2^bit)^2 - root^2
   assign trial = (TW'(src_root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
   assign fits  = TW'(src_rem) >= trial;

   always_comb begin
      rem_in  = src_rem;
      root_in = src_root;
      if (fits) begin
         rem_in  = RW'(TW'(src_rem) - trial);
         root_in = src_root | (QW'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign dst_rem  = rem_ff;
   assign dst_root = root_ff;
endmodule

// ----- design/qte_norm_cell.sv -----
// one step of the binary normalising shift ahead of the cordic
module qte_norm_cell #(
   parameter int SHIFT = 1
) (
   input  logic                    clock,
   input  logic                    en,
   input  qte_pkg::cordic_vec_type src,
   output qte_pkg::cordic_vec_type dst
);
   import qte_pkg::*;

   logic [CW-1:0]  mag_x, mag_y;
   logic           room;
   cordic_vec_type vec_ff, vec_in;

   assign mag_x = src.x[CW-1] ? CW'(-src.x) : CW'(src.x);
   assign mag_y = src.y[CW-1] ? CW'(-src.y) : CW'(src.y);
   // shift only while the larger magnitude stays below the target bit
   assign room  = ((mag_x | mag_y) >> (NORM_TOP + 1 - SHIFT)) == '0;

   always_comb begin
      vec_in = src;
      if (room) begin
         vec_in.x = src.x <<< SHIFT;
         vec_in.y = src.y <<< SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign dst = vec_ff;
endmodule

// ----- design/qte_cordic_cell.sv -----
// one vectoring cordic micro-rotation
module qte_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                    clock,
   input  logic                    en,
   input  qte_pkg::cordic_vec_type src,
   output qte_pkg::cordic_vec_type dst
);
   import qte_pkg::*;

   localparam logic signed [ZW-1:0] STEP_ANGLE = ZW'(ATAN_TAB[STAGE]);

   logic signed [CW-1:0] dx, dy;
   logic                 y_pos;
   cordic_vec_type       vec_ff, vec_in;

   assign dx    = src.y >>> STAGE;
   assign dy    = src.x >>> STAGE;
   assign y_pos = !src.y[CW-1] && (src.y != '0);

   // rotate towards the x axis unless the angle is already fixed
   always_comb begin
      vec_in = src;
      if (!src.hold) begin
         if (y_pos) begin
            vec_in.x = src.x + dx;
            vec_in.y = src.y - dy;
            vec_in.z = src.z + STEP_ANGLE;
         end else begin
            vec_in.x = src.x - dx;
            vec_in.y = src.y + dy;
            vec_in.z = src.z - STEP_ANGLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign dst = vec_ff;
endmodule

// ----- design/qte_lane.sv -----
// atan2 lane: quadrant fold, normalising cells, then a row of cordic cells
module qte_lane #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [qte_pkg::OW-1:0] src_y,
   input  logic signed [qte_pkg::OW-1:0] src_x,
   output logic signed [qte_pkg::ZW-1:0] dst_angle
);
   import qte_pkg::*;

   logic signed [CW-1:0] ext_x, ext_y;
   cordic_vec_type       fold_ff, fold_in;
   cordic_vec_type       norm_chain [NORM_CELLS+1];
   cordic_vec_type       rot_chain [CORDIC_STAGES+1];

   assign ext_x = CW'(src_x);
   assign ext_y = CW'(src_y);

   // fold the left half plane and catch a zero numerator
   always_comb begin
      fold_in.x    = ext_x;
      fold_in.y    = ext_y;
      fold_in.z    = '0;
      fold_in.hold = 1'b0;
      if (src_y == '0) begin
         fold_in.hold = 1'b1;
         fold_in.z    = src_x[OW-1] ? PI_Q30 : '0;
      end else if (src_x[OW-1]) begin
         fold_in.x = -ext_x;
         fold_in.y = -ext_y;
         fold_in.z = src_y[OW-1] ? -PI_Q30 : PI_Q30;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fold_ff <= fold_in;
      end
   end

   assign norm_chain[0] = fold_ff;

   for (genvar k = 0; k < NORM_CELLS; k++) begin : g_norm
      qte_norm_cell #(.SHIFT(NORM_FIRST >> k)) u_norm (
         .clock (clock),
         .en    (en),
         .src   (norm_chain[k]),
         .dst   (norm_chain[k+1])
      );
   end

   assign rot_chain[0] = norm_chain[NORM_CELLS];

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
      qte_cordic_cell #(.STAGE(k)) u_rot (
         .clock (clock),
         .en    (en),
         .src   (rot_chain[k]),
         .dst   (rot_chain[k+1])
      );
   end

   assign dst_angle = rot_chain[CORDIC_STAGES].z;
endmodule

// ----- design/quaternion_to_euler_angles.sv -----
// quaternion to x-y-z euler angles, fully pipelined
// throughput: one quaternion per cycle while the output is not blocked; the cordic and square root rows are unrolled
// a waiting result stalls the pipeline only once its last stage is occupied
// reset clears all valid flags and selects radians
module quaternion_to_euler_angles #(
   parameter int CORDIC_STAGES = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   qte_stream_if.sink   req_ch,
   qte_stream_if.source rsp_ch,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import qte_pkg::*;

   localparam int FRONT_STAGES = 5;
   localparam int LANE_LAT = 1 + NORM_CELLS + CORDIC_STAGES;
   localparam int PIPE_DEPTH = FRONT_STAGES + SQRT_BITS + LANE_LAT + 1;
   localparam int LAST = PIPE_DEPTH - 1;
   localparam int LANES = 3;
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;
   localparam int RAD_SHIFT = 33 - ANGLE_BITS;
   localparam int DEG_SHIFT = 55 - ANGLE_BITS;
   localparam int PW = ZW + 23;
   localparam logic signed [63:0] RAD_HALF = 64'sd1 <<< (RAD_SHIFT - 1);
   localparam logic signed [63:0] DEG_HALF = 64'sd1 <<< (DEG_SHIFT - 1);

   typedef struct packed {
      logic signed [OW-1:0] sx;
      logic signed [OW-1:0] cx;
      logic signed [OW-1:0] sz;
      logic signed [OW-1:0] cz;
      logic signed [OW-1:0] sy;
      logic                 sat;
      logic                 sy_pos;
   } side_type;

   typedef struct packed {
      logic sat;
      logic sy_pos;
   } flag_type;

   logic                  en;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  deg_ff;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   req_payload_type      in_ff;
   logic signed [31:0]   p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_wz_ff;
   logic signed [31:0]   p_xy_ff, p_zz_ff, p_wy_ff, p_zx_ff;
   side_type             side_c_ff, side_c_in, side_d_ff, side_d_in, side_e_ff;
   logic [OW-1:0]        sy_abs;
   logic [55:0]          sq_ff;
   logic [RW-1:0]        rem_ff;
   side_type             side_dly_ff [SQRT_BITS];
   logic [RW-1:0]        rem_chain [SQRT_BITS+1];
   logic [QW-1:0]        root_chain [SQRT_BITS+1];
   flag_type             flag_ff [LANE_LAT];
   logic signed [OW-1:0] lane_y [LANES];
   logic signed [OW-1:0] lane_x [LANES];
   logic signed [ZW-1:0] lane_ang [LANES];
   logic signed [ZW-1:0] sel_ang [LANES];
   logic signed [ZW-1:0] ang_ff [LANES];
   logic signed [PW-1:0] prod_ff [LANES];
   logic signed [15:0]   scaled [LANES];
   logic                 sat_ff;

   // advance unless the last stage holds an item and the output is blocked
   assign en = !vld_ff[LAST] || !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // valid flags along the pipeline
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // unit select register
   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff <= 1'b0;
      end else if (csr_wr_en) begin
         deg_ff <= csr_wr_data;
      end
   end

   // input capture and products
   always_ff @(posedge clock) begin
      if (en) begin
         in_ff   <= req_ch.payload;
         p_wx_ff <= in_ff.quat_w * in_ff.quat_x;
         p_yz_ff <= in_ff.quat_y * in_ff.quat_z;
         p_xx_ff <= in_ff.quat_x * in_ff.quat_x;
         p_yy_ff <= in_ff.quat_y * in_ff.quat_y;
         p_wz_ff <= in_ff.quat_w * in_ff.quat_z;
         p_xy_ff <= in_ff.quat_x * in_ff.quat_y;
         p_zz_ff <= in_ff.quat_z * in_ff.quat_z;
         p_wy_ff <= in_ff.quat_w * in_ff.quat_y;
         p_zx_ff <= in_ff.quat_z * in_ff.quat_x;
      end
   end

   // sines and cosines with 28 fraction bits
   always_comb begin
      side_c_in.sx     = (OW'(p_wx_ff) + OW'(p_yz_ff)) <<< 1;
      side_c_in.cx     = ONE_Q28 - ((OW'(p_xx_ff) + OW'(p_yy_ff)) <<< 1);
      side_c_in.sz     = (OW'(p_wz_ff) + OW'(p_xy_ff)) <<< 1;
      side_c_in.cz     = ONE_Q28 - ((OW'(p_yy_ff) + OW'(p_zz_ff)) <<< 1);
      side_c_in.sy     = (OW'(p_wy_ff) - OW'(p_zx_ff)) <<< 1;
      side_c_in.sat    = 1'b0;
      side_c_in.sy_pos = 1'b0;
   end

   assign sy_abs = side_c_ff.sy[OW-1] ? OW'(-side_c_ff.sy) : OW'(side_c_ff.sy);

   // saturation and sign of the asin argument
   always_comb begin
      side_d_in        = side_c_ff;
      side_d_in.sat    = sy_abs[OW-1:28] != '0;
      side_d_in.sy_pos = !side_c_ff.sy[OW-1];
   end

   // square of the asin argument, then the radicand 1 - s^2
   always_ff @(posedge clock) begin
      if (en) begin
         side_c_ff <= side_c_in;
         side_d_ff <= side_d_in;
         sq_ff     <= 56'(sy_abs[27:0]) * 56'(sy_abs[27:0]);
         side_e_ff <= side_d_ff;
         rem_ff    <= (RW'(1) << 56) - RW'(sq_ff);
      end
   end

   // square root row, with the other operands delayed alongside
   assign rem_chain[0]  = rem_ff;
   assign root_chain[0] = '0;

   for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
      qte_sqrt_cell #(.BIT(SQRT_BITS - 1 - k)) u_sqrt (
         .clock    (clock),
         .en       (en),
         .src_rem  (rem_chain[k]),
         .src_root (root_chain[k]),
         .dst_rem  (rem_chain[k+1]),
         .dst_root (root_chain[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_dly_ff[0] <= side_e_ff;
         for (int k = 1; k < SQRT_BITS; k++) begin
            side_dly_ff[k] <= side_dly_ff[k-1];
         end
      end
   end

   // three atan2 lanes
   assign lane_y[LANE_X] = side_dly_ff[SQRT_BITS-1].sx;
   assign lane_x[LANE_X] = side_dly_ff[SQRT_BITS-1].cx;
   assign lane_y[LANE_Y] = side_dly_ff[SQRT_BITS-1].sy;
   assign lane_x[LANE_Y] = OW'(root_chain[SQRT_BITS]);
   assign lane_y[LANE_Z] = side_dly_ff[SQRT_BITS-1].sz;
   assign lane_x[LANE_Z] = side_dly_ff[SQRT_BITS-1].cz;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      qte_lane #(.CORDIC_STAGES(CORDIC_STAGES)) u_lane (
         .clock     (clock),
         .en        (en),
         .src_y     (lane_y[l]),
         .src_x     (lane_x[l]),
         .dst_angle (lane_ang[l])
      );
   end

   // saturation flags follow the lanes
   always_ff @(posedge clock) begin
      if (en) begin
         flag_ff[0].sat    <= side_dly_ff[SQRT_BITS-1].sat;
         flag_ff[0].sy_pos <= side_dly_ff[SQRT_BITS-1].sy_pos;
         for (int k = 1; k < LANE_LAT; k++) begin
            flag_ff[k] <= flag_ff[k-1];
         end
      end
   end

   // clamp the asin angle at a quarter turn
   always_comb begin
      sel_ang[LANE_X] = lane_ang[LANE_X];
      sel_ang[LANE_Z] = lane_ang[LANE_Z];
      sel_ang[LANE_Y] = lane_ang[LANE_Y];
      if (flag_ff[LANE_LAT-1].sat) begin
         sel_ang[LANE_Y] = flag_ff[LANE_LAT-1].sy_pos ? HALF_PI_Q30 : -HALF_PI_Q30;
      end
   end

   // degree product
   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff <= flag_ff[LANE_LAT-1].sat;
         for (int l = 0; l < LANES; l++) begin
            ang_ff[l]  <= sel_ang[l];
            prod_ff[l] <= PW'(sel_ang[l]) * PW'(DEG_PER_RAD_Q16);
         end
      end
   end

   // round half up into the output format
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (deg_ff) begin
            scaled[l] = 16'((64'(prod_ff[l]) + DEG_HALF) >>> DEG_SHIFT);
         end else begin
            scaled[l] = 16'((64'(ang_ff[l]) + RAD_HALF) >>> RAD_SHIFT);
         end
      end
   end

   always_comb begin
      rsp_payload_in.angle_about_x = scaled[LANE_X];
      rsp_payload_in.angle_about_y = scaled[LANE_Y];
      rsp_payload_in.angle_about_z = scaled[LANE_Z];
      rsp_payload_in.y_saturated   = sat_ff;
   end

   // output register
   always_comb begin
      rsp_vld_in = rsp_vld_ff && !rsp_ch.ready;
      if (vld_ff[LAST] && en) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vld_ff[LAST] && en) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_ch.valid   = rsp_vld_ff;
   assign rsp_ch.payload = rsp_payload_ff;

`ifndef SYNTH
   // an input transfer enters the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> vld_ff[0])
      else $error("accepted item not in first stage");

   // a stalled pipeline keeps every item in place
   assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   // the last stage moves into the output register
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAST] && en) |=> rsp_vld_ff)
      else $error("item lost at output register");

   // no transfer while the last stage and the output are both blocked
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ch.ready && vld_ff[LAST]) |-> !req_ch.ready)
      else $error("input taken while pipeline full");
`endif
endmodule
